/* design/line_profile_extremum_picker_top_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef LINE_PROFILE_EXTREMUM_PICKER_TOP_DEFINES_SVH
`define LINE_PROFILE_EXTREMUM_PICKER_TOP_DEFINES_SVH

// Property sampled on clk and disabled while arst_n is low.
`define LPEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define LPEP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* design/lpep_pkg.sv */
package lpep_pkg;

	localparam int PIX_BITS   = 8;
	localparam int ALPHA_BITS = 9;

	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 9'd256;
	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 9'd128;
	localparam logic [PIX_BITS-1:0]   MIN_RESET   = 8'd255;
	localparam logic [PIX_BITS-1:0]   MAX_RESET   = 8'd0;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_MUL1,
		ST_MUL2,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic accept;
		logic cap_mul1;
		logic cap_mul2;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

/* design/lpep_ctrl.sv */
module lpep_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_pixel,
	input  lpep_pkg::status_t status,
	output lpep_pkg::cmd_t    cmd,
	output logic              in_ready
);

	lpep_pkg::state_t state_q;
	lpep_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpep_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpep_pkg::ST_ACCUM: begin
				if (in_valid && last_pixel) begin
					state_d = lpep_pkg::ST_MUL1;
				end
			end
			lpep_pkg::ST_MUL1: begin
				state_d = lpep_pkg::ST_MUL2;
			end
			lpep_pkg::ST_MUL2: begin
				state_d = lpep_pkg::ST_DECIDE;
			end
			lpep_pkg::ST_DECIDE: begin
				if (status.out_free) begin
					state_d = lpep_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = lpep_pkg::ST_ACCUM;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lpep_pkg::ST_ACCUM: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			lpep_pkg::ST_MUL1: begin
				cmd.cap_mul1 = 1'b1;
			end
			lpep_pkg::ST_MUL2: begin
				cmd.cap_mul2 = 1'b1;
			end
			lpep_pkg::ST_DECIDE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* design/lpep_dp.sv */
module lpep_dp #(
	parameter int COORD_BITS   = 12,
	parameter int MAX_LINE_LEN = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpep_pkg::cmd_t                      cmd,
	output lpep_pkg::status_t                   status,
	input  logic                                cfg_we,
	input  logic [lpep_pkg::ALPHA_BITS-1:0]     cfg_wdata,
	input  logic [lpep_pkg::PIX_BITS-1:0]       pixel_value,
	input  logic [COORD_BITS-1:0]               pixel_x,
	input  logic [COORD_BITS-1:0]               pixel_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_BITS-1:0]               point_x,
	output logic [COORD_BITS-1:0]               point_y,
	output logic                                chose_darkest
);

	localparam int PB = lpep_pkg::PIX_BITS;
	localparam int AB = lpep_pkg::ALPHA_BITS;
	localparam int CW = $clog2(MAX_LINE_LEN + 1);
	localparam int SW = CW + PB;
	localparam int TW = AB + PB;
	localparam int RW = TW + CW;
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LINE_LEN);

	logic [AB-1:0]         alpha_q;
	logic [PB-1:0]         run_min_q;
	logic [PB-1:0]         run_max_q;
	logic [COORD_BITS-1:0] min_x_q;
	logic [COORD_BITS-1:0] min_y_q;
	logic [COORD_BITS-1:0] max_x_q;
	logic [COORD_BITS-1:0] max_y_q;
	logic [SW-1:0]         sum_q;
	logic [CW-1:0]         count_q;

	logic [SW-1:0]         nmin_q;
	logic [TW-1:0]         coef_span_q;
	logic [SW-1:0]         excess_q;
	logic [RW-1:0]         rhs_q;

	logic [COORD_BITS-1:0] point_x_q;
	logic [COORD_BITS-1:0] point_y_q;
	logic                  dark_q;
	logic                  out_valid_q;

	logic [AB-1:0]         coef;
	logic [PB-1:0]         span;
	logic [RW-1:0]         lhs;
	logic                  dark;

	always_comb begin
		coef = lpep_pkg::ALPHA_ONE - ((alpha_q > lpep_pkg::ALPHA_ONE) ? lpep_pkg::ALPHA_ONE : alpha_q);
		span = run_max_q - run_min_q;
		lhs  = RW'({excess_q, {PB{1'b0}}});
		dark = lhs > rhs_q;
	end

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= lpep_pkg::ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// Line state; cleared when the decision for a line leaves for the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= lpep_pkg::MIN_RESET;
			run_max_q <= lpep_pkg::MAX_RESET;
			min_x_q   <= '0;
			min_y_q   <= '0;
			max_x_q   <= '0;
			max_y_q   <= '0;
			sum_q     <= '0;
			count_q   <= '0;
		end else if (cmd.load_out) begin
			run_min_q <= lpep_pkg::MIN_RESET;
			run_max_q <= lpep_pkg::MAX_RESET;
			min_x_q   <= '0;
			min_y_q   <= '0;
			max_x_q   <= '0;
			max_y_q   <= '0;
			sum_q     <= '0;
			count_q   <= '0;
		end else if (cmd.accept && (count_q != FULL_COUNT)) begin
			if (count_q == '0) begin
				run_min_q <= pixel_value;
				run_max_q <= pixel_value;
				min_x_q   <= pixel_x;
				min_y_q   <= pixel_y;
				max_x_q   <= pixel_x;
				max_y_q   <= pixel_y;
			end else begin
				if (pixel_value > run_max_q) begin
					run_max_q <= pixel_value;
					max_x_q   <= pixel_x;
					max_y_q   <= pixel_y;
				end
				if (pixel_value < run_min_q) begin
					run_min_q <= pixel_value;
					min_x_q   <= pixel_x;
					min_y_q   <= pixel_y;
				end
			end
			sum_q   <= sum_q + SW'(pixel_value);
			count_q <= count_q + 1'b1;
		end
	end

	// Decision terms: n*min and (256-alpha)*span, then sum-n*min and the full right side.
	always_ff @(posedge clk) begin
		if (cmd.cap_mul1) begin
			nmin_q      <= SW'(count_q) * SW'(run_min_q);
			coef_span_q <= TW'(coef) * TW'(span);
		end
		if (cmd.cap_mul2) begin
			excess_q <= sum_q - nmin_q;
			rhs_q    <= RW'(coef_span_q) * RW'(count_q);
		end
		if (cmd.load_out) begin
			point_x_q <= dark ? min_x_q : max_x_q;
			point_y_q <= dark ? min_y_q : max_y_q;
			dark_q    <= dark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign point_x       = point_x_q;
	assign point_y       = point_y_q;
	assign chose_darkest = dark_q;

endmodule

/* design/line_profile_extremum_picker_top.sv */
// Picks one extremum point per sampled line. Pixels are taken one word per
// cycle while accumulating a line; the running minimum, maximum, their first
// positions, the sum and the count are updated in that same cycle. The word
// flagged last_pixel starts a decision of three steps (two multiply stages
// and a compare), during which in_ready is low. The result sits in an output
// register, so pixels of the next line are taken while it waits; the decision
// of that next line holds until the register is free. alpha_q is written
// through cfg_we/cfg_wdata; the user must write it between lines only, as the
// block itself does not enforce it; values above 256 act as 256.
module line_profile_extremum_picker_top #(
	parameter int COORD_BITS   = 12,
	parameter int MAX_LINE_LEN = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpep_pkg::ALPHA_BITS-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lpep_pkg::PIX_BITS-1:0]   pixel_value,
	input  logic [COORD_BITS-1:0]           pixel_x,
	input  logic [COORD_BITS-1:0]           pixel_y,
	input  logic                            last_pixel,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [COORD_BITS-1:0]           point_x,
	output logic [COORD_BITS-1:0]           point_y,
	output logic                            chose_darkest
);

	lpep_pkg::cmd_t    cmd;
	lpep_pkg::status_t status;

	lpep_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_pixel (last_pixel),
		.status     (status),
		.cmd        (cmd),
		.in_ready   (in_ready)
	);

	lpep_dp #(
		.COORD_BITS   (COORD_BITS),
		.MAX_LINE_LEN (MAX_LINE_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pixel_value   (pixel_value),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.chose_darkest (chose_darkest)
	);

endmodule

/* design/lpep_checker.sv */
`include "line_profile_extremum_picker_top_defines.svh"

module lpep_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  last_pixel,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] point_x,
	input logic [COORD_BITS-1:0] point_y,
	input logic                  chose_darkest
);

	// A stalled result word must hold.
	`LPEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y) && $stable(chose_darkest), "result word changed while stalled")

	// The last word of a line closes the input for the decision cycles.
	`LPEP_ASSERT(a_decide_busy, in_valid && in_ready && last_pixel |=> !in_ready ##1 !in_ready ##1 !in_ready, "input reopened during decision")

	// A new result only comes out of a decision, when the input was closed.
	`LPEP_ASSERT_NEVER(a_result_src, $rose(out_valid) && $past(in_ready), "result appeared without a decision")

endmodule

bind line_profile_extremum_picker_top lpep_checker #(.COORD_BITS(COORD_BITS)) u_lpep_checker (.*);
